FILE: sv/mtxp_pkg.sv
// Package for the Manchester transmitter with preamble.
// Holds operation codes, default parameter values and fixed field widths.
// No dependencies.
`default_nettype none

package mtxp_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam int BUFFER_DEPTH_DEF        = 16;
  localparam int PREAMBLE_EXTRA_BITS_DEF = 16;

  localparam logic [31:0] PREAMBLE_HIGH_ONES = 32'hFFFF_0000;

  localparam int PATTERN_W = 16;
  localparam int INDEX_W   = 4;
  localparam int BYTE_W    = 8;
  localparam int LENGTH_W  = 5;
  localparam int BITCNT_W  = 6;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 8;

endpackage

`default_nettype wire

FILE: sv/manchester_tx_with_preamble.sv
// Manchester packet transmitter with preamble: top level.
// Depends on mtxp_pkg for operation codes, widths and defaults.
//
// Usage:
//   Input stream s_*: s_tuser carries the operation (write byte, start, half-bit
//   tick, no-op); s_tdata carries byte index, byte value and packet length. Each item
//   accepted yields exactly one item on m_*: m_tdata holds the line level and
//   busy flag, m_tlast is high on the tick that ends a packet.
//   cfg_we/cfg_wdata load the 16-bit preamble pattern; write only while idle.
// Timing and throughput:
//   The result of an item appears on m_* the cycle after it is accepted. One
//   item per cycle is sustained while m_tready stays high: all state updates for
//   an item are registered when it is accepted, and the single output register frees as it is read.
// Reset:
//   rst clears the sequencer, the pattern and the output register; the byte
//   buffer keeps whatever it held and must be written before use.
// Stall:
//   While m_tvalid is high and m_tready low the result holds and s_tready is
//   low; s_tready returns in the cycle the result is taken.
`default_nettype none

module manchester_tx_with_preamble #(
  parameter int BUFFER_DEPTH        = mtxp_pkg::BUFFER_DEPTH_DEF,
  parameter int PREAMBLE_EXTRA_BITS = mtxp_pkg::PREAMBLE_EXTRA_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [mtxp_pkg::PATTERN_W-1:0]   cfg_wdata,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [mtxp_pkg::IN_DATA_W-1:0]   s_tdata,  // byte_index, byte_value, packet_length
  input  wire logic [1:0]                       s_tuser,  // operation
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [mtxp_pkg::OUT_DATA_W-1:0]       m_tdata,  // line_level, busy_res
  output logic                                  m_tlast   // done_pulse
);

  localparam int STORE_DEPTH = (BUFFER_DEPTH < 16) ? BUFFER_DEPTH : 16;
  localparam int IDXW        = $clog2(STORE_DEPTH);
  localparam logic [mtxp_pkg::LENGTH_W-1:0] LEN_MAX =
    mtxp_pkg::LENGTH_W'((BUFFER_DEPTH > 31) ? 31 : BUFFER_DEPTH);
  localparam logic [mtxp_pkg::BITCNT_W-1:0] PRE_BITS =
    mtxp_pkg::BITCNT_W'(PREAMBLE_EXTRA_BITS + 16);
  localparam logic [7:0] DEPTH8 = 8'(BUFFER_DEPTH);

  logic [mtxp_pkg::BYTE_W-1:0]    packet_buffer [STORE_DEPTH];
  logic [mtxp_pkg::PATTERN_W-1:0] preamble_pattern;
  logic [31:0]                    preamble_shift, preamble_shift_next;
  logic [mtxp_pkg::BITCNT_W-1:0]  bit_counter, bit_counter_next;
  logic [mtxp_pkg::LENGTH_W-1:0]  byte_counter, byte_counter_next;
  logic [mtxp_pkg::LENGTH_W-1:0]  length_register, length_register_next;
  logic in_preamble, in_preamble_next;
  logic half_phase, half_phase_next;
  logic last_flag, last_flag_next;
  logic active_flag, active_flag_next;
  logic level_register, level_register_next;
  logic done_next;

  mtxp_pkg::op_t                  op;
  logic [mtxp_pkg::INDEX_W-1:0]   wr_index;
  logic [mtxp_pkg::BYTE_W-1:0]    wr_value;
  logic [mtxp_pkg::LENGTH_W-1:0]  start_len;
  logic                           accept;
  logic                           wr_en;
  logic [mtxp_pkg::BITCNT_W-1:0]  rd_bit_inc;
  logic [mtxp_pkg::LENGTH_W-1:0]  rd_sel_byte;
  logic [2:0]                     rd_sel_bit;
  logic [7:0]                     rd_ext;
  logic [IDXW-1:0]                rd_idx;
  logic [mtxp_pkg::BYTE_W-1:0]    rd_byte;
  logic                           cur_bit;

  assign op        = mtxp_pkg::op_t'(s_tuser);
  assign wr_index  = s_tdata[3:0];
  assign wr_value  = s_tdata[11:4];
  assign start_len = s_tdata[16:12];
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign wr_en     = accept && (op == mtxp_pkg::OP_WRITE) && (8'(wr_index) < DEPTH8);

  // Bit currently addressed by the next counter values
  assign rd_bit_inc  = bit_counter + 1'b1;
  assign rd_sel_byte = (half_phase && (rd_bit_inc >= mtxp_pkg::BITCNT_W'(8))) ?
                       byte_counter + 1'b1 : byte_counter;
  assign rd_sel_bit  = in_preamble ? 3'd0 :
                       (half_phase ? rd_bit_inc[2:0] : bit_counter[2:0]);
  assign rd_ext  = 8'(rd_sel_byte);
  assign rd_idx  = rd_ext[IDXW-1:0];
  assign rd_byte = packet_buffer[rd_idx];
  assign cur_bit = (rd_ext < DEPTH8) ? rd_byte[~rd_sel_bit] : 1'b0;

  always_comb begin
    logic [mtxp_pkg::BITCNT_W-1:0] bc_inc;
    logic [31:0]                   shifted;
    bc_inc               = bit_counter + 1'b1;
    shifted              = {preamble_shift[30:0], 1'b0};
    preamble_shift_next  = preamble_shift;
    bit_counter_next     = bit_counter;
    byte_counter_next    = byte_counter;
    length_register_next = length_register;
    in_preamble_next     = in_preamble;
    half_phase_next      = half_phase;
    last_flag_next       = last_flag;
    active_flag_next     = active_flag;
    level_register_next  = level_register;
    done_next            = 1'b0;
    if (accept) begin
      unique case (op)
        mtxp_pkg::OP_START: begin
          priority if (start_len == '0) begin
            length_register_next = mtxp_pkg::LENGTH_W'(1);
          end else if (start_len > LEN_MAX) begin
            length_register_next = LEN_MAX;
          end else begin
            length_register_next = start_len;
          end
          preamble_shift_next = mtxp_pkg::PREAMBLE_HIGH_ONES | 32'(preamble_pattern);
          bit_counter_next    = '0;
          byte_counter_next   = '0;
          in_preamble_next    = 1'b1;
          half_phase_next     = 1'b0;
          last_flag_next      = 1'b0;
          active_flag_next    = 1'b1;
          level_register_next = 1'b1;
        end
        mtxp_pkg::OP_TICK: begin
          if (active_flag) begin
            priority if (in_preamble) begin
              preamble_shift_next = shifted;
              if (bc_inc == PRE_BITS) begin
                in_preamble_next    = 1'b0;
                bit_counter_next    = '0;
                level_register_next = cur_bit;
              end else begin
                bit_counter_next    = bc_inc;
                level_register_next = shifted[31];
              end
            end else if (half_phase) begin
              half_phase_next = 1'b0;
              if (bc_inc >= mtxp_pkg::BITCNT_W'(8)) begin
                bit_counter_next  = '0;
                byte_counter_next = byte_counter + 1'b1;
                if (byte_counter_next == length_register) begin
                  last_flag_next = 1'b1;
                end
              end else begin
                bit_counter_next = bc_inc;
              end
              level_register_next = last_flag_next ? 1'b0 : cur_bit;
            end else begin
              half_phase_next = 1'b1;
              if (last_flag) begin
                active_flag_next = 1'b0;
                done_next        = 1'b1;
              end else begin
                level_register_next = !cur_bit;
              end
            end
          end
        end
        mtxp_pkg::OP_WRITE, mtxp_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      packet_buffer[wr_index[IDXW-1:0]] <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_pattern <= '0;
      preamble_shift   <= '0;
      bit_counter      <= '0;
      byte_counter     <= '0;
      length_register  <= '0;
      in_preamble      <= 1'b0;
      half_phase       <= 1'b0;
      last_flag        <= 1'b0;
      active_flag      <= 1'b0;
      level_register   <= 1'b0;
      m_tvalid         <= 1'b0;
      m_tdata          <= '0;
      m_tlast          <= 1'b0;
    end else begin
      if (cfg_we) begin
        preamble_pattern <= cfg_wdata;
      end
      preamble_shift  <= preamble_shift_next;
      bit_counter     <= bit_counter_next;
      byte_counter    <= byte_counter_next;
      length_register <= length_register_next;
      in_preamble     <= in_preamble_next;
      half_phase      <= half_phase_next;
      last_flag       <= last_flag_next;
      active_flag     <= active_flag_next;
      level_register  <= level_register_next;
      if (accept) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {6'b0, active_flag_next, level_register_next};
        m_tlast  <= done_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/mtxp_checker.sv
// Port-level checker for the Manchester transmitter, with its bind.
// Depends on mtxp_pkg for the start operation code.
`default_nettype none

module mtxp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tlast
);

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item gave no result");

  a_start_drives_high: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == mtxp_pkg::OP_START)
    |=> m_tvalid && m_tdata[0] && m_tdata[1])
    else $error("start did not raise line and busy");

  a_done_is_idle_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[1] && !m_tdata[0])
    else $error("done reported while busy or line high");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

endmodule

bind manchester_tx_with_preamble mtxp_checker u_mtxp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: bench/tb_manchester_tx_with_preamble.sv
// Self-checking bench for manchester_tx_with_preamble: buffer writes, packet starts and
// half-bit ticks drive the stream port, and a scoreboard predicts each line level item.
// Depends on mtxp_pkg and the top level of the block only.
`timescale 1ns / 100ps

module tb_manchester_tx_with_preamble;

  localparam int DEPTH     = mtxp_pkg::BUFFER_DEPTH_DEF;
  localparam int PRE_TICKS = mtxp_pkg::PREAMBLE_EXTRA_BITS_DEF + 16;

  class line_scoreboard;
    typedef struct packed {
      logic level;
      logic done;
      logic busy;
    } line_item_t;

    line_item_t  levels_due[$];
    int          errors;
    logic [7:0]  buffer [DEPTH];
    logic [31:0] pre_shift;
    logic [5:0]  bit_cnt;
    logic [4:0]  byte_cnt;
    logic [4:0]  len_reg;
    logic [15:0] pattern;
    logic        in_pre, half, last, active, level;

    function new();
      foreach (buffer[i]) buffer[i] = 8'h00;
      pre_shift = '0;
      bit_cnt   = '0;
      byte_cnt  = '0;
      len_reg   = '0;
      pattern   = '0;
      in_pre    = 1'b0;
      half      = 1'b0;
      last      = 1'b0;
      active    = 1'b0;
      level     = 1'b0;
      errors    = 0;
    endfunction

    function void set_pattern(logic [15:0] v);
      pattern = v;
    endfunction

    function bit busy();
      return active;
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    local function logic bit_now();
      logic [7:0] b;
      b = (byte_cnt < DEPTH) ? buffer[byte_cnt] : 8'h00;
      return b[3'd7 - bit_cnt[2:0]];
    endfunction

    local function void half_bit_tick(output logic done);
      done = 1'b0;
      if (active) begin
        if (in_pre) begin
          pre_shift = pre_shift << 1;
          bit_cnt   = bit_cnt + 6'd1;
          if (bit_cnt == PRE_TICKS) begin
            in_pre  = 1'b0;
            bit_cnt = '0;
            level   = bit_now();
          end else begin
            level = pre_shift[31];
          end
        end else if (half) begin
          half    = 1'b0;
          bit_cnt = bit_cnt + 6'd1;
          if (bit_cnt >= 8) begin
            bit_cnt  = '0;
            byte_cnt = byte_cnt + 5'd1;
            if (byte_cnt == len_reg) last = 1'b1;
          end
          level = last ? 1'b0 : bit_now();
        end else begin
          half = 1'b1;
          if (last) begin
            active = 1'b0;
            done   = 1'b1;
          end else begin
            level = ~bit_now();
          end
        end
      end
    endfunction

    function void note_item(mtxp_pkg::op_t op, logic [3:0] idx, logic [7:0] val,
                            logic [4:0] len);
      logic       done;
      line_item_t res;
      done = 1'b0;
      case (op)
        mtxp_pkg::OP_WRITE: begin
          if (idx < DEPTH) buffer[idx] = val;
        end
        mtxp_pkg::OP_START: begin
          if (len == 0) len = 5'd1;
          if (len > DEPTH) len = 5'(DEPTH);
          pre_shift = mtxp_pkg::PREAMBLE_HIGH_ONES | {16'h0000, pattern};
          bit_cnt   = '0;
          byte_cnt  = '0;
          len_reg   = len;
          in_pre    = 1'b1;
          half      = 1'b0;
          last      = 1'b0;
          active    = 1'b1;
          level     = 1'b1;
        end
        mtxp_pkg::OP_TICK: half_bit_tick(done);
        default: ;
      endcase
      res.level = level;
      res.done  = done;
      res.busy  = active;
      levels_due.push_back(res);
    endfunction

    function void check_result(logic [mtxp_pkg::OUT_DATA_W-1:0] data, logic last_bit);
      line_item_t exp_res;
      if (levels_due.size() == 0) begin
        $display("%0t: unexpected item, line_level %0b busy %0b done %0b",
                 $time, data[0], data[1], last_bit);
        errors++;
      end else begin
        exp_res = levels_due.pop_front();
        if (data[0] !== exp_res.level) begin
          $display("%0t: line_level expected %0b actual %0b", $time, exp_res.level, data[0]);
          errors++;
        end
        if (data[1] !== exp_res.busy) begin
          $display("%0t: busy expected %0b actual %0b", $time, exp_res.busy, data[1]);
          errors++;
        end
        if (last_bit !== exp_res.done) begin
          $display("%0t: done expected %0b actual %0b", $time, exp_res.done, last_bit);
          errors++;
        end
      end
    endfunction
  endclass

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_we    = 1'b0;
  logic [mtxp_pkg::PATTERN_W-1:0]  cfg_wdata = '0;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [mtxp_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
  logic [1:0]                      s_tuser   = '0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [mtxp_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tlast;

  line_scoreboard sb = new();
  int             items_sent = 0;
  int             stall_left = 0;
  bit             quiet      = 1'b0;

  manchester_tx_with_preamble u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [4:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 5'($urandom_range(1, 3));
    if (r < 90) return 5'($urandom_range(4, 8));
    if (r < 93) return 5'd0;
    if (r < 96) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(9, 16));
  endfunction

  task automatic send_item(mtxp_pkg::op_t op, logic [3:0] idx, logic [7:0] val,
                           logic [4:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'b0, len, val, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_item(op, idx, val, len);
    items_sent++;
  endtask

  task automatic send_op(mtxp_pkg::op_t op);
    send_item(op, 4'($urandom), 8'($urandom), 5'($urandom));
  endtask

  task automatic start_packet(logic [4:0] len);
    send_item(mtxp_pkg::OP_START, 4'($urandom), 8'($urandom), len);
  endtask

  task automatic run_to_done();
    while (sb.busy()) send_op(mtxp_pkg::OP_TICK);
  endtask

  task automatic set_preamble(logic [15:0] v);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_pattern(v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready   <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    logic [7:0]  seed_bytes [DEPTH];
    logic [15:0] phase_pattern [4];
    int          phase_end;
    int          r;

    seed_bytes = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h80, 8'h01, 8'hF0, 8'h0F,
                   8'hCC, 8'h33, 8'h7E, 8'h81, 8'hFE, 8'h7F, 8'h96, 8'h69};
    phase_pattern = '{16'hFFFF, 16'($urandom), 16'h0000, 16'($urandom)};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle: no-op code and a tick change nothing
    send_op(mtxp_pkg::OP_NONE);
    send_op(mtxp_pkg::OP_TICK);
    foreach (seed_bytes[i]) send_item(mtxp_pkg::OP_WRITE, 4'(i), seed_bytes[i], 5'($urandom));
    // length zero, then a write to the byte about to be sent and a no-op while busy
    start_packet(5'd0);
    repeat (5) send_op(mtxp_pkg::OP_TICK);
    send_item(mtxp_pkg::OP_WRITE, 4'd0, 8'h3C, 5'd0);
    send_op(mtxp_pkg::OP_NONE);
    run_to_done();
    send_op(mtxp_pkg::OP_TICK);
    // oversized length saturates; a restart abandons the packet in flight
    start_packet(5'd31);
    repeat (40) send_op(mtxp_pkg::OP_TICK);
    start_packet(5'd16);
    run_to_done();

    foreach (phase_pattern[p]) begin
      set_preamble(phase_pattern[p]);
      phase_end = items_sent + 320;
      while (items_sent < phase_end) begin
        quiet = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_op(mtxp_pkg::OP_NONE);
        end else if (r < 8) begin
          send_op(mtxp_pkg::OP_TICK);
        end else if (r < 12) begin
          send_op(mtxp_pkg::OP_WRITE);
        end else begin
          repeat ($urandom_range(0, 3)) send_op(mtxp_pkg::OP_WRITE);
          start_packet(pick_length());
          while (sb.busy()) begin
            r = $urandom_range(0, 999);
            if (r < 6) send_op(mtxp_pkg::OP_WRITE);
            else if (r < 8) send_op(mtxp_pkg::OP_NONE);
            else if (r < 10) start_packet(pick_length());
            else send_op(mtxp_pkg::OP_TICK);
          end
        end
      end
      quiet = 1'b0;
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
